### design/radix_digit_converter_assert.svh
// Assertion macros for the radix digit converter.
// Define NO_ASSERTIONS to compile them out.
`ifndef RADIX_DIGIT_CONVERTER_ASSERT_SVH
`define RADIX_DIGIT_CONVERTER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Check an implication at every rising edge while out of reset.
`define RDC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check an implication at every rising edge, reset included.
`define RDC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) \
        else $error(msg);

`else

`define RDC_ASSERT(label, prop, msg)
`define RDC_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

### design/rdc_pkg.sv
package rdc_pkg;

    localparam int RDC_VALUE_WIDTH = 31;

    typedef enum logic [1:0] {
        CMD_BIN = 2'd0,
        CMD_OCT = 2'd1,
        CMD_HEX = 2'd2,
        CMD_DEC = 2'd3
    } cmd_t;

    localparam logic [6:0] ASCII_ZERO  = 7'd48;
    localparam logic [6:0] ASCII_ALPHA = 7'd55;
    localparam logic [3:0] DEC_LIMIT   = 4'd10;

    // Microprogram step addresses
    typedef logic [2:0] step_t;
    localparam step_t STEP_IDLE   = 3'd0;
    localparam step_t STEP_BRANCH = 3'd1;
    localparam step_t STEP_DABBLE = 3'd2;
    localparam step_t STEP_BCD    = 3'd3;
    localparam step_t STEP_SKIP   = 3'd4;
    localparam step_t STEP_EMIT   = 3'd5;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_DABBLE,
        OP_LOAD_BCD,
        OP_SKIP,
        OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_START,
        COND_DEC,
        COND_MORE_IT,
        COND_LEAD_ZERO,
        COND_MORE_DIG
    } cond_t;

    // One control word: datapath op, branch condition, taken and fall targets
    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t jt;
        step_t nt;
    } uword_t;

    // Status from the datapath that the branch conditions test
    typedef struct packed {
        logic is_dec;
        logic more_it;
        logic lead_zero;
        logic more_dig;
    } dp_flags_t;

    function automatic uword_t ucode(step_t s);
        uword_t w;
        case (s)
            STEP_IDLE:   w = '{op: OP_LOAD,     cond: COND_START,
                               jt: STEP_BRANCH, nt: STEP_IDLE};
            STEP_BRANCH: w = '{op: OP_NOP,      cond: COND_DEC,
                               jt: STEP_DABBLE, nt: STEP_SKIP};
            STEP_DABBLE: w = '{op: OP_DABBLE,   cond: COND_MORE_IT,
                               jt: STEP_DABBLE, nt: STEP_BCD};
            STEP_BCD:    w = '{op: OP_LOAD_BCD, cond: COND_ALWAYS,
                               jt: STEP_SKIP,   nt: STEP_SKIP};
            STEP_SKIP:   w = '{op: OP_SKIP,     cond: COND_LEAD_ZERO,
                               jt: STEP_SKIP,   nt: STEP_EMIT};
            STEP_EMIT:   w = '{op: OP_EMIT,     cond: COND_MORE_DIG,
                               jt: STEP_EMIT,   nt: STEP_IDLE};
            default:     w = '{op: OP_NOP,      cond: COND_ALWAYS,
                               jt: STEP_IDLE,   nt: STEP_IDLE};
        endcase
        return w;
    endfunction

    function automatic logic [6:0] char_of(logic [3:0] d);
        logic [6:0] c;
        if (d < DEC_LIMIT)
            c = ASCII_ZERO + {3'b000, d};
        else
            c = ASCII_ALPHA + {3'b000, d};
        return c;
    endfunction

endpackage

### design/rdc_sequencer.sv
module rdc_sequencer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  rdc_pkg::dp_flags_t flags,
    output rdc_pkg::op_t      op,
    output logic              busy
);
    import rdc_pkg::*;

    step_t  upc_reg;
    step_t  upc_next;
    uword_t word;
    logic   taken;

    assign word = ucode(upc_reg);
    assign busy = (upc_reg != STEP_IDLE);

    always_comb
    begin
        case (word.cond)
            COND_ALWAYS:    taken = 1'b1;
            COND_START:     taken = start;
            COND_DEC:       taken = flags.is_dec;
            COND_MORE_IT:   taken = flags.more_it;
            COND_LEAD_ZERO: taken = flags.lead_zero;
            COND_MORE_DIG:  taken = flags.more_dig;
            default:        taken = 1'b0;
        endcase
    end

    // Hold the load back while idle without a start.
    assign op       = (word.cond == COND_START && !start) ? OP_NOP : word.op;
    assign upc_next = taken ? word.jt : word.nt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            upc_reg <= STEP_IDLE;
        else
            upc_reg <= upc_next;
    end

endmodule

### design/rdc_datapath.sv
module rdc_datapath #(
    parameter int VALUE_WIDTH = rdc_pkg::RDC_VALUE_WIDTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  rdc_pkg::op_t           op,
    input  logic [VALUE_WIDTH-1:0] value,
    input  logic [1:0]             command,
    output rdc_pkg::dp_flags_t     flags,
    output logic [3:0]             digit,
    output logic [6:0]             ascii_char,
    output logic                   last,
    output logic                   strobe
);
    import rdc_pkg::*;

    localparam int W    = VALUE_WIDTH;
    localparam int NDIG = (W * 30103) / 100000 + 1;   // decimal digits of 2^W-1
    localparam int BW   = NDIG * 4;
    localparam int N8   = (W + 2) / 3;
    localparam int N16  = (W + 3) / 4;
    localparam int M1   = (BW > N8 * 3) ? BW : N8 * 3;
    localparam int M2   = (M1 > N16 * 4) ? M1 : N16 * 4;
    localparam int SRW  = (M2 > W) ? M2 : W;
    localparam int CW   = $clog2(SRW + 1);

    cmd_t            cmd_reg,   cmd_next;
    logic [SRW-1:0]  sr_reg,    sr_next;
    logic [BW-1:0]   bcd_reg,   bcd_next;
    logic [CW-1:0]   it_reg,    it_next;
    logic [CW-1:0]   dcnt_reg,  dcnt_next;
    logic            strobe_reg, strobe_next;
    logic [3:0]      digit_reg,  digit_next;
    logic [6:0]      ascii_reg,  ascii_next;
    logic            last_reg,   last_next;

    logic [SRW-1:0]  val_ext;
    logic [SRW-1:0]  sr_adv;
    logic [3:0]      top;
    logic [BW-1:0]   bcd_adj;
    logic            final_dig;

    assign val_ext   = SRW'(value);
    assign final_dig = (dcnt_reg == CW'(1));

    // Leading digit of the work register and the register advanced past it
    always_comb
    begin
        case (cmd_reg)
            CMD_BIN:
            begin
                top    = {3'b000, sr_reg[SRW-1]};
                sr_adv = sr_reg << 1;
            end
            CMD_OCT:
            begin
                top    = {1'b0, sr_reg[SRW-1 -: 3]};
                sr_adv = sr_reg << 3;
            end
            default:
            begin
                top    = sr_reg[SRW-1 -: 4];
                sr_adv = sr_reg << 4;
            end
        endcase
    end

    // Add 3 to every BCD digit of five or more before the shift
    always_comb
    begin
        logic [3:0] nib;
        for (int i = 0; i < NDIG; i++)
        begin
            nib = bcd_reg[i*4 +: 4];
            bcd_adj[i*4 +: 4] = (nib >= 4'd5) ? nib + 4'd3 : nib;
        end
    end

    assign flags.is_dec    = (cmd_reg == CMD_DEC);
    assign flags.more_it   = (it_reg != CW'(1));
    assign flags.lead_zero = (top == 4'd0) && !final_dig;
    assign flags.more_dig  = !final_dig;

    always_comb
    begin
        cmd_next    = cmd_reg;
        sr_next     = sr_reg;
        bcd_next    = bcd_reg;
        it_next     = it_reg;
        dcnt_next   = dcnt_reg;
        strobe_next = 1'b0;
        digit_next  = digit_reg;
        ascii_next  = ascii_reg;
        last_next   = last_reg;
        case (op)
            OP_LOAD:
            begin
                cmd_next = cmd_t'(command);
                bcd_next = '0;
                it_next  = CW'(W);
                case (cmd_t'(command))
                    CMD_BIN:
                    begin
                        sr_next   = val_ext << (SRW - W);
                        dcnt_next = CW'(W);
                    end
                    CMD_OCT:
                    begin
                        sr_next   = val_ext << (SRW - N8 * 3);
                        dcnt_next = CW'(N8);
                    end
                    CMD_HEX:
                    begin
                        sr_next   = val_ext << (SRW - N16 * 4);
                        dcnt_next = CW'(N16);
                    end
                    default:
                    begin
                        sr_next   = val_ext << (SRW - W);
                        dcnt_next = CW'(NDIG);
                    end
                endcase
            end
            OP_DABBLE:
            begin
                bcd_next = {bcd_adj[BW-2:0], sr_reg[SRW-1]};
                sr_next  = sr_reg << 1;
                it_next  = it_reg - CW'(1);
            end
            OP_LOAD_BCD:
            begin
                sr_next = SRW'(bcd_reg) << (SRW - BW);
            end
            OP_SKIP:
            begin
                if (flags.lead_zero)
                begin
                    sr_next   = sr_adv;
                    dcnt_next = dcnt_reg - CW'(1);
                end
            end
            OP_EMIT:
            begin
                strobe_next = 1'b1;
                digit_next  = top;
                ascii_next  = char_of(top);
                last_next   = final_dig;
                sr_next     = sr_adv;
                dcnt_next   = dcnt_reg - CW'(1);
            end
            default:
            begin
                strobe_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            strobe_reg <= 1'b0;
        else
            strobe_reg <= strobe_next;
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        sr_reg    <= sr_next;
        bcd_reg   <= bcd_next;
        it_reg    <= it_next;
        dcnt_reg  <= dcnt_next;
        digit_reg <= digit_next;
        ascii_reg <= ascii_next;
        last_reg  <= last_next;
    end

    assign strobe     = strobe_reg;
    assign digit      = digit_reg;
    assign ascii_char = ascii_reg;
    assign last       = last_reg;

endmodule

### design/radix_digit_converter.sv
// Radix digit converter: turns a non-negative VALUE_WIDTH-bit number into its
// binary, octal, hexadecimal or decimal (BCD) digits.
// Input: drive value and command (0 bin, 1 oct, 2 hex, 3 dec) with start high;
// the transaction is taken at a rising edge where start is high and busy low.
// Output: one transaction per digit, most significant first, shown for exactly
// one cycle with strobe high: digit, ascii_char ('0'-'9', 'A'-'F') and last on
// the final digit. A zero value gives the single digit 0. Leading zeros drop.
// The microcode loads the value, then for decimal runs the double-dabble shifts
// and loads the BCD result into the work register; every digit slot after that
// is either dropped as a leading zero or emitted as a digit.
// busy falls in the cycle that shows the last strobe, so the next transaction
// can be taken at the edge that ends it.
// The receiver cannot stall; results are never held back or repeated.
// Reset (rst_n low, asynchronous) returns the step counter to idle and clears
// strobe; any conversion under way is dropped.
module radix_digit_converter #(
    parameter int VALUE_WIDTH = rdc_pkg::RDC_VALUE_WIDTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [VALUE_WIDTH-1:0] value,
    input  logic [1:0]             command,
    output logic                   strobe,
    output logic [3:0]             digit,
    output logic [6:0]             ascii_char,
    output logic                   last
);
    import rdc_pkg::*;

    `include "radix_digit_converter_assert.svh"

    op_t       op;
    dp_flags_t flags;

    // Step counter and control store: picks one datapath op per cycle and
    // branches on the datapath status flags.
    rdc_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .flags (flags),
        .op    (op),
        .busy  (busy)
    );

    // Work register, BCD accumulator, counters and output register.
    rdc_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (op),
        .value      (value),
        .command    (command),
        .flags      (flags),
        .digit      (digit),
        .ascii_char (ascii_char),
        .last       (last),
        .strobe     (strobe)
    );

    `RDC_ASSERT(a_no_strobe_after_accept, (start && !busy) |=> !strobe, "strobe after accept")
    `RDC_ASSERT(a_last_ends_run, (strobe && last) |=> !strobe, "digit after last")
    `RDC_ASSERT(a_mid_run_busy, (strobe && !last) |-> busy, "idle inside a run")
    `RDC_ASSERT(a_busy_from_start, $rose(busy) |-> $past(start), "busy without start")

endmodule

### verif/tb_radix_digit_converter.sv
module tb_radix_digit_converter;
    import rdc_pkg::*;

    localparam int W = RDC_VALUE_WIDTH;
    localparam logic [W-1:0] VALUE_MAX = {W{1'b1}};
    // The limit is many times the slowest run of about 360 conversions with their gaps.
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 340;

    // One conversion request and how the driver presents it
    typedef struct {
        logic [W-1:0] val;
        cmd_t         cmd;
        int           gap;    // idle cycles before start is raised
        logic         drain;  // hold off until every pending digit has come back
    } conv_req_t;

    // One digit that the converter should emit
    typedef struct {
        logic [3:0] digit;
        logic [6:0] ascii_char;
        logic       last;
    } digit_rec_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          start = 1'b0;
    logic [W-1:0]  value = '0;
    cmd_t          command = CMD_BIN;
    logic          busy;
    logic          strobe;
    logic [3:0]    digit;
    logic [6:0]    ascii_char;
    logic          last;

    conv_req_t     conv_requests[$];
    digit_rec_t    digits_due[$];
    int unsigned   error_count = 0;
    int unsigned   cycle_count = 0;

    radix_digit_converter u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .value      (value),
        .command    (command),
        .strobe     (strobe),
        .digit      (digit),
        .ascii_char (ascii_char),
        .last       (last)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Split the value into digits of the selected radix and queue them most
    // significant first; a zero value still yields one digit.
    task automatic push_expected_digits(input logic [W-1:0] val, input cmd_t cmd);
        longint unsigned rest;
        longint unsigned radix;
        logic [3:0]      msd_first[$];
        digit_rec_t      rec;
        rest = longint'(val);
        case (cmd)
            CMD_BIN: radix = 2;
            CMD_OCT: radix = 8;
            CMD_HEX: radix = 16;
            default: radix = 10;
        endcase
        do
        begin
            msd_first.push_front(4'(rest % radix));
            rest = rest / radix;
        end
        while (rest != 0);
        for (int k = 0; k < msd_first.size(); k++)
        begin
            rec.digit = msd_first[k];
            // Digits below ten map to '0'..'9', the rest to 'A'..'F'
            if (rec.digit < DEC_LIMIT)
                rec.ascii_char = ASCII_ZERO + {3'b000, rec.digit};
            else
                rec.ascii_char = ASCII_ALPHA + {3'b000, rec.digit};
            rec.last = (k == msd_first.size() - 1);
            digits_due.push_back(rec);
        end
    endtask

    function automatic void add_request(input logic [W-1:0] val, input cmd_t cmd,
                                        input int gap, input logic drain);
        conv_req_t r;
        r.val   = val;
        r.cmd   = cmd;
        r.gap   = gap;
        r.drain = drain;
        conv_requests.push_back(r);
    endfunction

    // Driver: present queued requests on start/value/command. A transaction is
    // taken at an edge where start is high and busy is low; on that edge,
    // record the digits it must produce and advance to the next request.
    always @(posedge clk)
    begin : drive_proc
        logic took;
        logic go;
        int   gap_left;
        logic gap_loaded;
        took = 1'b0;
        go   = 1'b0;
        if (rst_n)
        begin
            took = start && !busy;
            if (took)
            begin
                push_expected_digits(conv_requests[0].val, conv_requests[0].cmd);
                void'(conv_requests.pop_front());
                gap_loaded = 1'b0;
            end
            if (start && !took)
            begin
                // Hold the transaction until the block takes it
                go = 1'b1;
            end
            else if (conv_requests.size() > 0)
            begin
                if (!gap_loaded)
                begin
                    gap_left   = conv_requests[0].gap;
                    gap_loaded = 1'b1;
                end
                if (gap_left > 0)
                    gap_left--;
                else if (!(conv_requests[0].drain && digits_due.size() > 0))
                begin
                    go = 1'b1;
                    value   <= conv_requests[0].val;
                    command <= conv_requests[0].cmd;
                end
            end
        end
        else
        begin
            gap_loaded = 1'b0;
        end
        // Single update of start per edge so a back-to-back transaction keeps it high
        start <= go;
    end

    // Monitor: every strobe is one result transaction; match it against the
    // oldest expected digit, field by field.
    always @(posedge clk)
    begin : check_proc
        digit_rec_t want;
        if (rst_n && strobe)
        begin
            if (digits_due.size() == 0)
            begin
                $error("unexpected digit: digit %0d ascii_char %0d last %0d",
                       digit, ascii_char, last);
                error_count++;
            end
            else
            begin
                want = digits_due.pop_front();
                if (digit !== want.digit)
                begin
                    $error("digit: expected %0d, got %0d", want.digit, digit);
                    error_count++;
                end
                if (ascii_char !== want.ascii_char)
                begin
                    $error("ascii_char: expected %0d, got %0d", want.ascii_char, ascii_char);
                    error_count++;
                end
                if (last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, last);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Watchdog: drop the run if it hangs
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        logic [W-1:0] v;
        int           mode;
        int           gap;
        cmd_t         cmd;

        // Directed: zero and all-ones in every radix, digit boundaries, A-F
        add_request('0, CMD_BIN, 0, 1'b0);
        add_request('0, CMD_OCT, 0, 1'b0);
        add_request('0, CMD_HEX, 0, 1'b0);
        add_request('0, CMD_DEC, 2, 1'b0);
        add_request(VALUE_MAX, CMD_BIN, 0, 1'b0);
        add_request(VALUE_MAX, CMD_OCT, 0, 1'b0);
        add_request(VALUE_MAX, CMD_HEX, 1, 1'b0);
        add_request(VALUE_MAX, CMD_DEC, 0, 1'b0);
        add_request(W'(1), CMD_BIN, 0, 1'b0);
        add_request(W'(2), CMD_BIN, 3, 1'b0);
        add_request(W'(7), CMD_OCT, 0, 1'b0);
        add_request(W'(8), CMD_OCT, 0, 1'b0);
        add_request(W'(10), CMD_HEX, 0, 1'b0);
        add_request(W'(15), CMD_HEX, 0, 1'b0);
        add_request(W'(16), CMD_HEX, 4, 1'b1);
        add_request(W'(9), CMD_DEC, 0, 1'b0);
        add_request(W'(999999999), CMD_DEC, 0, 1'b0);
        add_request(W'(1000000000), CMD_DEC, 0, 1'b0);
        add_request(W'(1) << (W - 1), CMD_BIN, 0, 1'b0);
        add_request(W'(1) << (W - 1), CMD_DEC, 0, 1'b0);
        add_request(W'(32'h5555_5555), CMD_HEX, 0, 1'b0);
        add_request(W'(32'h2AAA_AAAA), CMD_OCT, 0, 1'b0);

        // Random: mix full-width, short and boundary values in every radix
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            mode = $urandom_range(0, 3);
            case (mode)
                0: v = W'($urandom);
                1: v = W'($urandom_range(0, 99));
                2: v = W'($urandom) >> $urandom_range(0, W - 1);
                default:
                begin
                    v = W'(1) << $urandom_range(0, W - 1);
                    if ($urandom_range(0, 1))
                        v = v - 1'b1;
                end
            endcase
            cmd = cmd_t'($urandom_range(0, 3));
            // Every fourth stretch of 30 has no idle gap; its first request still drains
            if ((i / 30) % 4 == 1)
                gap = 0;
            else
                gap = $urandom_range(0, 10);
            add_request(v, cmd, gap, (i % 60) == 30);
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (conv_requests.size() > 0 || start)
            @(posedge clk);
        while (digits_due.size() > 0)
            @(posedge clk);
        // Allow time for any stray strobe after the final digit
        repeat (60) @(posedge clk);

        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### filelist.f
+incdir+design
design/rdc_pkg.sv
design/rdc_sequencer.sv
design/rdc_datapath.sv
design/radix_digit_converter.sv
verif/tb_radix_digit_converter.sv
